FILE: hdl/assert_macros.svh
// Assertion macros used by the deframer checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check a consequent in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/fdx_pkg.sv
// Shared constants for the framed message deframer.
package fdx_pkg;

   localparam int BYTE_W = 8;
   localparam int POS_W  = 6;
   localparam int CNT_W  = 32;

   localparam logic [BYTE_W-1:0] CH_START = 8'h25;
   localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;
   localparam logic [BYTE_W-1:0] CH_CARET = 8'h5E;

   // length byte to stored byte count offset, counted up to and including the caret
   localparam logic [8:0] LEN_OFFSET = 9'd5;

   localparam logic EVT_BYTE     = 1'b0;
   localparam logic EVT_CSUM_ERR = 1'b1;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CNT_W-1:0]  count_type;

endpackage

FILE: hdl/fdx_channels.sv
// Request and response channel interfaces of the deframer.
interface fdx_req_if import fdx_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type rx_byte;
   logic     sensor_mode;

   modport source (output valid, output rx_byte, output sensor_mode, input ready);
   modport sink (input valid, input rx_byte, input sensor_mode, output ready);
   modport monitor (input valid, input rx_byte, input sensor_mode, input ready);
endinterface

interface fdx_rsp_if import fdx_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             event_res;
   byte_type         frame_byte;
   logic [POS_W-1:0] byte_position;
   logic             last;
   byte_type         message_id;
   logic             update_actuator;
   count_type        received_count;
   count_type        failed_count;

   modport source (output valid, output event_res, output frame_byte,
                   output byte_position, output last, output message_id,
                   output update_actuator, output received_count,
                   output failed_count, input ready);
   modport sink (input valid, input event_res, input frame_byte,
                 input byte_position, input last, input message_id,
                 input update_actuator, input received_count,
                 input failed_count, output ready);
   modport monitor (input valid, input event_res, input frame_byte,
                    input byte_position, input last, input message_id,
                    input update_actuator, input received_count,
                    input failed_count, input ready);
endinterface

FILE: hdl/framed_message_deframer_xor_check.sv
// Framed message deframer with XOR checksum, frame memory and readout sequencer.
//
// Bytes are taken one per cycle while a frame is parsed; each is written to the
// frame memory, and those from the id to the closing pair are folded into a running
// XOR. The checksum byte of a frame waits for a free response register. After a good
// frame the input holds while the checksummed span (N bytes, id first) is read back
// from the single read port of the frame memory; a response stall holds the readout.
// A mismatch gives one error transaction. No clearing pass after reset.
module framed_message_deframer_xor_check
   import fdx_pkg::*;
#(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic     clock,
   input  logic     reset,
   fdx_req_if.sink   req_chan,
   fdx_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(BUFFER_DEPTH);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_AMP     = 3'd1;
   localparam logic [2:0] PH_COLLECT = 3'd2;
   localparam logic [2:0] PH_TAIL    = 3'd3;
   localparam logic [2:0] PH_CHECK   = 3'd4;

   byte_type frame_mem [BUFFER_DEPTH];

   logic [2:0]    phase_ff, phase_in;
   logic [AW-1:0] wp_ff, wp_in;
   byte_type      len_ff, len_in;
   byte_type      id_ff, id_in;
   byte_type      xor_ff, xor_in;
   byte_type      prev1_ff, prev1_in;
   byte_type      prev2_ff, prev2_in;
   count_type     good_ff, good_in;
   count_type     bad_ff, bad_in;
   logic          latch_ff, latch_in;
   logic          upd_ff, upd_in;

   logic          read_active_ff, read_active_in;
   logic          issue_done_ff, issue_done_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic [AW-1:0] last_pos_ff, last_pos_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [AW-1:0] q_pos_ff;
   logic          q_last_ff;
   byte_type      mem_q_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_event_ff;
   byte_type         rsp_byte_ff;
   logic [POS_W-1:0] rsp_pos_ff;
   logic             rsp_last_ff;
   byte_type         rsp_id_ff;
   logic             rsp_upd_ff;
   count_type        rsp_good_ff;
   count_type        rsp_bad_ff;

   logic          req_fire;
   logic          rsp_free;
   logic          issue;
   logic          load_q;
   logic          err_load;
   logic          rd_is_last;
   logic [AW-1:0] wp_inc;
   byte_type      c;
   byte_type      len_eff;
   byte_type      csum;
   logic          len_match;

   assign c        = req_chan.rx_byte;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !read_active_ff && ((phase_ff != PH_CHECK) || rsp_free);
   assign req_fire = req_chan.valid && req_chan.ready;

   assign wp_inc    = wp_ff + AW'(1);
   assign len_eff   = (wp_ff == AW'(3)) ? c : len_ff;
   assign len_match = (wp_inc > AW'(3)) && (9'(wp_inc) == (9'(len_eff) + LEN_OFFSET));
   assign csum      = xor_ff ^ prev1_ff ^ prev2_ff;

   assign rd_is_last = (rd_addr_ff == last_pos_ff);
   assign load_q     = rd_valid_ff && rsp_free;
   assign issue      = read_active_ff && !issue_done_ff && (!rd_valid_ff || load_q);
   assign err_load   = req_fire && (phase_ff == PH_CHECK) && (csum != c);

   always_comb begin
      phase_in       = phase_ff;
      wp_in          = wp_ff;
      len_in         = len_ff;
      id_in          = id_ff;
      xor_in         = xor_ff;
      prev1_in       = prev1_ff;
      prev2_in       = prev2_ff;
      good_in        = good_ff;
      bad_in         = bad_ff;
      latch_in       = latch_ff;
      upd_in         = upd_ff;
      read_active_in = read_active_ff;
      issue_done_in  = issue_done_ff;
      rd_addr_in     = rd_addr_ff;
      last_pos_in    = last_pos_ff;

      if (req_fire) begin
         case (phase_ff)
            PH_AMP: begin
               if (c == CH_AMP) begin
                  wp_in    = wp_inc;
                  phase_in = PH_COLLECT;
                  xor_in   = '0;
               end else if (c != CH_START) begin
                  wp_in    = '0;
                  phase_in = PH_IDLE;
                  if (!latch_ff) begin
                     bad_in   = bad_ff + CNT_W'(1);
                     latch_in = 1'b1;
                  end
               end
            end
            PH_COLLECT: begin
               wp_in    = wp_inc;
               xor_in   = xor_ff ^ c;
               prev1_in = c;
               prev2_in = prev1_ff;
               if (wp_ff == AW'(2)) begin
                  id_in = c;
               end
               if (wp_ff == AW'(3)) begin
                  len_in = c;
               end
               if (len_match) begin
                  if (c == CH_CARET) begin
                     phase_in = PH_TAIL;
                  end else begin
                     wp_in    = '0;
                     phase_in = PH_IDLE;
                     bad_in   = bad_ff + CNT_W'(1);
                     latch_in = 1'b1;
                  end
               end else if (wp_inc == AW'(BUFFER_DEPTH - 3)) begin
                  wp_in    = '0;
                  phase_in = PH_IDLE;
                  bad_in   = bad_ff + CNT_W'(1);
                  latch_in = 1'b1;
               end
            end
            PH_TAIL: begin
               wp_in    = wp_inc;
               xor_in   = xor_ff ^ c;
               prev1_in = c;
               prev2_in = prev1_ff;
               if (c == CH_AMP) begin
                  phase_in = PH_CHECK;
               end else if (wp_inc == AW'(BUFFER_DEPTH - 2)) begin
                  wp_in    = '0;
                  phase_in = PH_IDLE;
               end
            end
            PH_CHECK: begin
               wp_in    = '0;
               phase_in = PH_IDLE;
               if (csum == c) begin
                  good_in        = good_ff + CNT_W'(1);
                  latch_in       = 1'b0;
                  upd_in         = (id_ff == 8'd1) && !req_chan.sensor_mode;
                  read_active_in = 1'b1;
                  issue_done_in  = 1'b0;
                  rd_addr_in     = AW'(2);
                  last_pos_in    = wp_ff - AW'(3);
               end else begin
                  bad_in   = bad_ff + CNT_W'(1);
                  latch_in = 1'b1;
               end
            end
            default: begin
               if (c == CH_START) begin
                  wp_in    = AW'(1);
                  phase_in = PH_AMP;
               end else begin
                  wp_in    = '0;
                  phase_in = PH_IDLE;
                  if (!latch_ff) begin
                     bad_in   = bad_ff + CNT_W'(1);
                     latch_in = 1'b1;
                  end
               end
            end
         endcase
      end

      // advance the readout
      if (issue) begin
         rd_addr_in = rd_addr_ff + AW'(1);
         if (rd_is_last) begin
            issue_done_in = 1'b1;
         end
      end
      if (load_q && q_last_ff) begin
         read_active_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_q || err_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      rd_valid_in = rd_valid_ff;
      if (issue) begin
         rd_valid_in = 1'b1;
      end else if (load_q) begin
         rd_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         frame_mem[wp_ff] <= c;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         mem_q_ff  <= frame_mem[rd_addr_ff];
         q_pos_ff  <= rd_addr_ff;
         q_last_ff <= rd_is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         wp_ff          <= '0;
         good_ff        <= '0;
         bad_ff         <= '0;
         latch_ff       <= 1'b0;
         read_active_ff <= 1'b0;
         issue_done_ff  <= 1'b0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         wp_ff          <= wp_in;
         good_ff        <= good_in;
         bad_ff         <= bad_in;
         latch_ff       <= latch_in;
         read_active_ff <= read_active_in;
         issue_done_ff  <= issue_done_in;
         rd_valid_ff    <= rd_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      id_ff       <= id_in;
      xor_ff      <= xor_in;
      prev1_ff    <= prev1_in;
      prev2_ff    <= prev2_in;
      upd_ff      <= upd_in;
      rd_addr_ff  <= rd_addr_in;
      last_pos_ff <= last_pos_in;
   end

   always_ff @(posedge clock) begin
      if (load_q) begin
         rsp_event_ff <= EVT_BYTE;
         rsp_byte_ff  <= mem_q_ff;
         rsp_pos_ff   <= POS_W'(q_pos_ff);
         rsp_last_ff  <= q_last_ff;
         rsp_id_ff    <= id_ff;
         rsp_upd_ff   <= upd_ff;
         rsp_good_ff  <= good_ff;
         rsp_bad_ff   <= bad_ff;
      end else if (err_load) begin
         rsp_event_ff <= EVT_CSUM_ERR;
         rsp_byte_ff  <= '0;
         rsp_pos_ff   <= '0;
         rsp_last_ff  <= 1'b1;
         rsp_id_ff    <= id_ff;
         rsp_upd_ff   <= 1'b0;
         rsp_good_ff  <= good_in;
         rsp_bad_ff   <= bad_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.event_res       = rsp_event_ff;
   assign rsp_chan.frame_byte      = rsp_byte_ff;
   assign rsp_chan.byte_position   = rsp_pos_ff;
   assign rsp_chan.last            = rsp_last_ff;
   assign rsp_chan.message_id      = rsp_id_ff;
   assign rsp_chan.update_actuator = rsp_upd_ff;
   assign rsp_chan.received_count  = rsp_good_ff;
   assign rsp_chan.failed_count    = rsp_bad_ff;

endmodule

FILE: hdl/fdx_checker.sv
// Port-level assertion checker for the deframer, bound into the deframer module.
`include "assert_macros.svh"

module fdx_checker
   import fdx_pkg::*;
(
   input logic       clock,
   input logic       reset,
   fdx_req_if.sink   req_chan,
   fdx_rsp_if.source rsp_chan
);

   logic                    err_rsp;
   logic                    err_clean;
   logic                    mid_span;
   logic                    upd_rsp;
   logic                    upd_ok;
   logic                    rsp_wait;
   logic [BYTE_W+POS_W:0]   rsp_view;

   assign err_rsp   = rsp_chan.valid && (rsp_chan.event_res == EVT_CSUM_ERR);
   assign err_clean = rsp_chan.last && (rsp_chan.frame_byte == '0) &&
                      (rsp_chan.byte_position == '0) && !rsp_chan.update_actuator;
   assign mid_span  = rsp_chan.valid && (rsp_chan.event_res == EVT_BYTE) && !rsp_chan.last;
   assign upd_rsp   = rsp_chan.valid && rsp_chan.update_actuator;
   assign upd_ok    = (rsp_chan.message_id == 8'd1) && (rsp_chan.event_res == EVT_BYTE);
   assign rsp_wait  = rsp_chan.valid && !rsp_chan.ready;
   assign rsp_view  = {rsp_chan.frame_byte, rsp_chan.byte_position, rsp_chan.last};

   `ASSERT_SAME(a_err_fields, clock, reset, err_rsp, err_clean)
   `ASSERT_SAME(a_span_holds_input, clock, reset, mid_span, !req_chan.ready)
   `ASSERT_SAME(a_update_id, clock, reset, upd_rsp, upd_ok)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_chan.valid && $stable(rsp_view))

endmodule

bind framed_message_deframer_xor_check fdx_checker u_fdx_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
